>>> hw/rtl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and constants for the fragment message reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package fmr_pkg;

   localparam int PACKET_BYTES_DEF = 32;
   localparam int CHUNK_BYTES_DEF  = 29;
   localparam int HEAD_BYTES       = 3;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // holds packet count times chunk size for any legal chunk size
   localparam int PADDED_W = 13;

   localparam logic [4:0] PAD_MASK     = 5'h1F;
   localparam logic [7:0] CAPACITY_RST = 8'd255;

   localparam logic [2:0] ST_SUCCESS    = 3'd0;
   localparam logic [2:0] ST_TIMEOUT    = 3'd1;
   localparam logic [2:0] ST_BAD_PAD    = 3'd2;
   localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW   = 3'd4;
   localparam logic [2:0] ST_BAD_PACKET = 3'd5;

   localparam logic MODE_BYTE    = 1'b0;
   localparam logic MODE_TIMEOUT = 1'b1;

   typedef struct packed {
      logic [7:0] message_length;
      logic [2:0] status;
      logic       done_res;
      logic       byte_last;
      logic [7:0] message_byte;
      logic       byte_valid;
   } fmr_result_type;

endpackage

`default_nettype wire

>>> hw/rtl/fmr_queue.sv
// ----------------------------------------------------------------------------
// fmr_queue
// Small register FIFO between the packet parser and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module fmr_queue #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic             not_empty,
   output      logic [WIDTH-1:0] head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fmr_front.sv
// ----------------------------------------------------------------------------
// fmr_front
// Packet parser: tracks byte position and phase, checks headers and builds
// at most one result per input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module fmr_front
   import fmr_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic           mode,
   input  wire logic [7:0]     rx_byte,
   input  wire logic [7:0]     capacity,
   output      logic           push,
   output      fmr_result_type result
);

   localparam int DATA_BYTES = (CHUNK_BYTES < PACKET_BYTES - HEAD_BYTES) ?
                               CHUNK_BYTES : PACKET_BYTES - HEAD_BYTES;
   localparam int POS_W = $clog2(PACKET_BYTES);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PACKET_BYTES - 1);
   localparam logic [4:0]       PAD_LIMIT  = 5'(DATA_BYTES - 1);
   localparam logic [5:0]       DATA_CNT   = 6'(DATA_BYTES);

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_RECV,
      PH_DROP
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [7:0]           cur_idx_ff, cur_idx_in;
   logic [7:0]           tot_pkts_ff, tot_pkts_in;
   logic [PADDED_W-1:0]  padded_ff, padded_in;
   logic [4:0]           pad_ff, pad_in;
   logic [7:0]           hdr_idx_ff, hdr_idx_in;
   logic [7:0]           length_ff, length_in;

   logic [4:0]           pad_new;
   logic [PADDED_W-1:0]  pad_ext;
   logic [PADDED_W-1:0]  size_diff;
   logic [8:0]           idx_next;
   logic                 final_pkt;
   logic [5:0]           k_pos;
   logic [5:0]           count;
   logic                 last_byte;

   always_comb begin
      pad_new   = rx_byte[4:0] & PAD_MASK;
      pad_ext   = PADDED_W'(pad_new);
      size_diff = padded_ff - pad_ext;
      idx_next  = {1'b0, cur_idx_ff} + 9'd1;
      final_pkt = (idx_next == {1'b0, tot_pkts_ff});
      k_pos     = 6'(pos_ff) - 6'(HEAD_BYTES);
      count     = final_pkt ? (DATA_CNT - 6'(pad_ff)) : DATA_CNT;
      last_byte = final_pkt && ((k_pos + 6'd1) == count);
   end

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      cur_idx_in  = cur_idx_ff;
      tot_pkts_in = tot_pkts_ff;
      padded_in   = padded_ff;
      pad_in      = pad_ff;
      hdr_idx_in  = hdr_idx_ff;
      length_in   = length_ff;
      push        = 1'b0;
      result      = '0;

      if (accept) begin
         if (mode == MODE_TIMEOUT) begin
            push                  = 1'b1;
            result.done_res       = 1'b1;
            result.status         = ST_TIMEOUT;
            result.message_length = (phase_ff == PH_RECV) ? length_ff : 8'd0;
            phase_in              = PH_WAIT;
            pos_in                = '0;
            length_in             = 8'd0;
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  if (pos_ff == POS_W'(0)) begin
                     hdr_idx_in = rx_byte;
                  end else if (pos_ff == POS_W'(1)) begin
                     tot_pkts_in = rx_byte;
                     padded_in   = PADDED_W'(rx_byte) * PADDED_W'(DATA_BYTES);
                  end else if (pos_ff == POS_W'(2)) begin
                     pad_in = pad_new;
                     if (pad_new > PAD_LIMIT) begin
                        push          = 1'b1;
                        result.status = ST_BAD_PAD;
                        phase_in      = PH_DROP;
                     end else if (padded_ff <= pad_ext) begin
                        push          = 1'b1;
                        result.status = ST_BAD_SIZE;
                        phase_in      = PH_DROP;
                     end else if (size_diff > PADDED_W'(capacity)) begin
                        push          = 1'b1;
                        result.status = ST_OVERFLOW;
                        phase_in      = PH_DROP;
                     end else begin
                        length_in = size_diff[7:0];
                        if (hdr_idx_ff != 8'd0) begin
                           push                  = 1'b1;
                           result.status         = ST_BAD_PACKET;
                           result.message_length = size_diff[7:0];
                           phase_in              = PH_DROP;
                        end else begin
                           cur_idx_in = 8'd0;
                           phase_in   = PH_RECV;
                        end
                     end
                     result.done_res = push;
                  end
               end
               PH_RECV: begin
                  if (pos_ff == POS_W'(0)) begin
                     if (({1'b0, rx_byte} != idx_next) || (rx_byte >= tot_pkts_ff)) begin
                        push                  = 1'b1;
                        result.done_res       = 1'b1;
                        result.status         = ST_BAD_PACKET;
                        result.message_length = length_ff;
                        phase_in              = PH_DROP;
                     end else begin
                        cur_idx_in = rx_byte;
                     end
                  end else if (6'(pos_ff) >= 6'(HEAD_BYTES)) begin
                     if (k_pos < count) begin
                        push                = 1'b1;
                        result.byte_valid   = 1'b1;
                        result.message_byte = rx_byte;
                        result.byte_last    = last_byte;
                        result.done_res     = last_byte;
                        result.status       = ST_SUCCESS;
                        result.message_length = last_byte ? length_ff : 8'd0;
                        if (last_byte) begin
                           phase_in = PH_DROP;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase

            if (pos_ff == POS_LAST) begin
               pos_in = '0;
               if (phase_in == PH_DROP) begin
                  phase_in  = PH_WAIT;
                  length_in = 8'd0;
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         pos_ff      <= '0;
         cur_idx_ff  <= 8'd0;
         tot_pkts_ff <= 8'd0;
         padded_ff   <= '0;
         pad_ff      <= 5'd0;
         hdr_idx_ff  <= 8'd0;
         length_ff   <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         cur_idx_ff  <= cur_idx_in;
         tot_pkts_ff <= tot_pkts_in;
         padded_ff   <= padded_in;
         pad_ff      <= pad_in;
         hdr_idx_ff  <= hdr_idx_in;
         length_ff   <= length_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fragment_message_reassembler_top.sv
// ----------------------------------------------------------------------------
// fragment_message_reassembler_top
// Rebuilds one message from fixed-size radio packets received byte by byte.
// ----------------------------------------------------------------------------
// One input transaction per clock: each byte (or timeout event) is parsed in
// the cycle it is accepted, and any result is written into a small FIFO that
// drives the rsp port. req_tready drops only while that FIFO is full, so the
// rate is one transaction per cycle as long as the rsp side keeps taking
// results. Headers are checked on the third byte of the first packet; data
// bytes come out one per transaction with the final one carrying the success
// status and length. Errors and timeouts emit a status and no data byte.
// dest_capacity must be written through csr_ while idle; it is not checked.
`default_nettype none

module fragment_message_reassembler_top
   import fmr_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] mode
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [7:0] message_byte, [10:8] status,
                                         // [18:11] message_length, rest zero
   output      logic        rsp_tlast,   // byte_last
   output      logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] done_res
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_data    // dest_capacity
);

   localparam int RES_W = $bits(fmr_result_type);

   logic [7:0]     cap_ff;
   logic           accept;
   logic           push;
   logic           full;
   fmr_result_type result;
   fmr_result_type head;
   logic [RES_W-1:0] head_bits;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   fmr_front #(
      .PACKET_BYTES (PACKET_BYTES),
      .CHUNK_BYTES  (CHUNK_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mode     (req_tuser),
      .rx_byte  (req_tdata),
      .capacity (cap_ff),
      .push     (push),
      .result   (result)
   );

   fmr_queue #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (full),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .head_data (head_bits)
   );

   assign head = fmr_result_type'(head_bits);

   always_comb begin
      rsp_tdata       = '0;
      rsp_tdata[7:0]  = head.message_byte;
      rsp_tdata[10:8] = head.status;
      rsp_tdata[18:11] = head.message_length;
      rsp_tlast       = head.byte_last;
      rsp_tuser       = {head.done_res, head.byte_valid};
   end

endmodule

`default_nettype wire
